// ===== rtl/defr_pkg.sv =====
// Shared types, codes and the CRC-8 table function for the dual encoder frame receiver.
`default_nettype none

package defr_pkg;

   // Beat commands on the request channel
   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_BYTE  = 2'd1;
   localparam logic [1:0] CMD_TICK  = 2'd2;

   // Encoder request codes
   localparam logic [7:0] CODE_DUAL        = 8'h33;
   localparam logic [7:0] CODE_DUAL_STATUS = 8'h43;
   localparam logic [7:0] CODE_TEMP        = 8'h74;

   // Reply lengths in bytes, CRC byte included
   localparam logic [3:0] LEN_DUAL        = 4'd7;
   localparam logic [3:0] LEN_DUAL_STATUS = 4'd8;
   localparam logic [3:0] LEN_TEMP        = 4'd3;

   // Reply kinds
   localparam logic [1:0] RK_DUAL        = 2'd0;
   localparam logic [1:0] RK_DUAL_STATUS = 2'd1;
   localparam logic [1:0] RK_TEMP        = 2'd2;

   // Response beat kinds
   localparam logic KIND_TX      = 1'b0;
   localparam logic KIND_OUTCOME = 1'b1;

   // Transaction outcomes
   localparam logic [2:0] OUT_OK      = 3'd0;
   localparam logic [2:0] OUT_CRC     = 3'd1;
   localparam logic [2:0] OUT_TIMEOUT = 3'd2;
   localparam logic [2:0] OUT_BUSY    = 3'd3;
   localparam logic [2:0] OUT_UNKNOWN = 3'd4;

   // Register indexes
   localparam logic CSR_TIMEOUT_TICKS    = 1'b0;
   localparam logic CSR_REFUSE_WHEN_BUSY = 1'b1;

   localparam logic [15:0] TIMEOUT_RESET = 16'd10;
   localparam logic [7:0]  CRC_POLY      = 8'h97;

   // Decoded fields presented by the frame store
   typedef struct packed {
      logic [23:0]        inner_angle;
      logic [23:0]        outer_angle;
      logic [7:0]         encoder_status;
      logic signed [15:0] temperature;
   } frame_fields_type;

   // One response beat
   typedef struct packed {
      logic               kind;
      logic [7:0]         tx_byte;
      logic [2:0]         outcome;
      logic [23:0]        inner_angle;
      logic [23:0]        outer_angle;
      logic [7:0]         encoder_status;
      logic               status_valid;
      logic signed [15:0] temperature;
      logic [1:0]         reply_kind;
   } rsp_payload_type;

   // Table value of the MSB-first CRC-8, zero init
   function automatic logic [7:0] crc_table_entry(input logic [7:0] v);
      logic [7:0] c;
      c = v;
      for (int i = 0; i < 8; i++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/defr_req_if.sv =====
// Request channel: start, reply byte and tick beats.
`default_nettype none

interface defr_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [7:0] command_code;
   logic [7:0] rx_byte;

   modport source (output valid, output cmd, output command_code, output rx_byte,
                   input ready);
   modport sink   (input valid, input cmd, input command_code, input rx_byte,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/defr_rsp_if.sv =====
// Response channel: command bytes to send and transaction outcomes.
`default_nettype none

interface defr_rsp_if;
   logic               valid;
   logic               ready;
   logic               kind;
   logic [7:0]         tx_byte;
   logic [2:0]         outcome;
   logic [23:0]        inner_angle;
   logic [23:0]        outer_angle;
   logic [7:0]         encoder_status;
   logic               status_valid;
   logic signed [15:0] temperature;
   logic [1:0]         reply_kind;

   modport source (output valid, output kind, output tx_byte, output outcome,
                   output inner_angle, output outer_angle, output encoder_status,
                   output status_valid, output temperature, output reply_kind,
                   input ready);
   modport sink   (input valid, input kind, input tx_byte, input outcome,
                   input inner_angle, input outer_angle, input encoder_status,
                   input status_valid, input temperature, input reply_kind,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/defr_frame_store.sv =====
// Reply byte store with little-endian field unpacking.
`default_nettype none

module defr_frame_store
   import defr_pkg::*;
#(
   parameter int FRAME_BYTES = 8,
   localparam int IDX_W = $clog2(FRAME_BYTES)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [IDX_W-1:0] wr_addr,
   input  wire logic [7:0]       wr_data,
   output frame_fields_type      fields
);

   logic [7:0] store_ff [FRAME_BYTES];

   // Byte write, one per reply beat
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // Fixed taps: angles in bytes 0..5, status in byte 6, temperature in 0..1
   assign fields.inner_angle    = {store_ff[2], store_ff[1], store_ff[0]};
   assign fields.outer_angle    = {store_ff[5], store_ff[4], store_ff[3]};
   assign fields.encoder_status = store_ff[6];
   assign fields.temperature    = signed'({store_ff[1], store_ff[0]});

endmodule

`default_nettype wire

// ===== rtl/dual_encoder_frame_receiver.sv =====
// Top level of the dual encoder frame receiver.
`default_nettype none

// Takes one request beat per clock and produces at most one response beat for it, in the
// next cycle in a response register; a new beat is accepted whenever that register is
// empty or being taken, so the rate is one beat per cycle. A start with code 0x33, 0x43
// or 0x74 returns the code as a byte to send and arms the receiver for a 7, 8 or 3 byte
// reply; reply bytes fold into a CRC-8 (poly 0x97) through one table lookup per beat,
// and the last byte returns the outcome, with the decoded fields on a clean CRC. Ticks
// count to a timeout on tick timeout_ticks+1 after the start. Unknown codes are refused.
module dual_encoder_frame_receiver
   import defr_pkg::*;
#(
   parameter int FRAME_BYTES = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_wdata,
   defr_req_if.sink         req_chan,
   defr_rsp_if.source       rsp_chan
);

   localparam int IDX_W = $clog2(FRAME_BYTES);

   // Configuration
   logic [15:0] timeout_ticks_ff;
   logic        refuse_when_busy_ff;

   // Transfer state
   logic        busy_ff, busy_in;
   logic [1:0]  reply_type_ff, reply_type_in;
   logic [3:0]  expected_length_ff, expected_length_in;
   logic [3:0]  byte_count_ff, byte_count_in;
   logic [7:0]  crc_ff, crc_in;
   logic [15:0] tick_count_ff, tick_count_in;

   // Response register
   logic            rsp_valid_ff;
   rsp_payload_type rsp_ff;

   logic             fire;
   logic             res_valid;
   rsp_payload_type  res;
   logic             store_we;
   frame_fields_type fields;
   logic             code_known;
   logic [1:0]       code_type;
   logic [3:0]       code_len;
   logic [7:0]       crc_next;
   logic [3:0]       count_next;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign fire = req_chan.valid && req_chan.ready;

   defr_frame_store #(.FRAME_BYTES(FRAME_BYTES)) u_store (
      .clock   (clock),
      .wr_en   (fire && store_we),
      .wr_addr (byte_count_ff[IDX_W-1:0]),
      .wr_data (req_chan.rx_byte),
      .fields  (fields)
   );

   // Request code decode
   always_comb begin
      code_known = 1'b1;
      code_type  = RK_DUAL;
      code_len   = LEN_DUAL;
      unique case (req_chan.command_code)
         CODE_DUAL: begin
            code_type = RK_DUAL;
            code_len  = LEN_DUAL;
         end
         CODE_DUAL_STATUS: begin
            code_type = RK_DUAL_STATUS;
            code_len  = LEN_DUAL_STATUS;
         end
         CODE_TEMP: begin
            code_type = RK_TEMP;
            code_len  = LEN_TEMP;
         end
         default: code_known = 1'b0;
      endcase
   end

   // CRC fold: first byte loads directly
   assign crc_next   = (byte_count_ff == 4'd0) ? req_chan.rx_byte
                                               : (req_chan.rx_byte ^ crc_table_entry(crc_ff));
   assign count_next = byte_count_ff + 4'd1;

   // Beat handling and next state
   always_comb begin
      busy_in            = busy_ff;
      reply_type_in      = reply_type_ff;
      expected_length_in = expected_length_ff;
      byte_count_in      = byte_count_ff;
      crc_in             = crc_ff;
      tick_count_in      = tick_count_ff;
      store_we           = 1'b0;
      res_valid          = 1'b0;
      res                = '0;
      case (req_chan.cmd)
         CMD_START: begin
            res_valid = 1'b1;
            if (!code_known) begin
               res.kind    = KIND_OUTCOME;
               res.outcome = OUT_UNKNOWN;
            end else if (busy_ff && refuse_when_busy_ff) begin
               res.kind    = KIND_OUTCOME;
               res.outcome = OUT_BUSY;
            end else begin
               busy_in            = 1'b1;
               reply_type_in      = code_type;
               expected_length_in = code_len;
               byte_count_in      = 4'd0;
               crc_in             = 8'd0;
               tick_count_in      = 16'd0;
               res.kind           = KIND_TX;
               res.tx_byte        = req_chan.command_code;
            end
         end
         CMD_BYTE: begin
            if (busy_ff) begin
               store_we      = ({1'b0, byte_count_ff} < 5'(FRAME_BYTES));
               crc_in        = crc_next;
               byte_count_in = count_next;
               if (count_next >= expected_length_ff) begin
                  // Last byte: a clean frame leaves the register at zero
                  busy_in        = 1'b0;
                  res_valid      = 1'b1;
                  res.kind       = KIND_OUTCOME;
                  res.reply_kind = reply_type_ff;
                  if (crc_next != 8'd0) begin
                     res.outcome = OUT_CRC;
                  end else begin
                     res.outcome = OUT_OK;
                     if (reply_type_ff == RK_TEMP) begin
                        res.temperature = fields.temperature;
                     end else begin
                        res.inner_angle = fields.inner_angle;
                        res.outer_angle = fields.outer_angle;
                        if (reply_type_ff == RK_DUAL_STATUS) begin
                           res.encoder_status = fields.encoder_status;
                           res.status_valid   = 1'b1;
                        end
                     end
                  end
               end
            end
         end
         CMD_TICK: begin
            if (busy_ff && timeout_ticks_ff != 16'd0) begin
               if (tick_count_ff >= timeout_ticks_ff) begin
                  busy_in        = 1'b0;
                  res_valid      = 1'b1;
                  res.kind       = KIND_OUTCOME;
                  res.outcome    = OUT_TIMEOUT;
                  res.reply_kind = reply_type_ff;
               end else begin
                  tick_count_in = tick_count_ff + 16'd1;
               end
            end
         end
         default: ;
      endcase
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ticks_ff    <= TIMEOUT_RESET;
         refuse_when_busy_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TIMEOUT_TICKS:    timeout_ticks_ff    <= csr_wdata;
            CSR_REFUSE_WHEN_BUSY: refuse_when_busy_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Transfer state, updated on accepted beats
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff            <= 1'b0;
         reply_type_ff      <= 2'd0;
         expected_length_ff <= 4'd0;
         byte_count_ff      <= 4'd0;
         crc_ff             <= 8'd0;
         tick_count_ff      <= 16'd0;
      end else if (fire) begin
         busy_ff            <= busy_in;
         reply_type_ff      <= reply_type_in;
         expected_length_ff <= expected_length_in;
         byte_count_ff      <= byte_count_in;
         crc_ff             <= crc_in;
         tick_count_ff      <= tick_count_in;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         rsp_valid_ff <= fire && res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready) begin
         rsp_ff <= res;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.kind           = rsp_ff.kind;
   assign rsp_chan.tx_byte        = rsp_ff.tx_byte;
   assign rsp_chan.outcome        = rsp_ff.outcome;
   assign rsp_chan.inner_angle    = rsp_ff.inner_angle;
   assign rsp_chan.outer_angle    = rsp_ff.outer_angle;
   assign rsp_chan.encoder_status = rsp_ff.encoder_status;
   assign rsp_chan.status_valid   = rsp_ff.status_valid;
   assign rsp_chan.temperature    = rsp_ff.temperature;
   assign rsp_chan.reply_kind     = rsp_ff.reply_kind;

   // A finishing outcome leaves the receiver idle
   a_finish_idles: assert property (@(posedge clock) disable iff (reset)
      (fire && res_valid && res.kind == KIND_OUTCOME &&
       (res.outcome == OUT_OK || res.outcome == OUT_CRC || res.outcome == OUT_TIMEOUT))
      |=> !busy_ff)
      else $error("receiver still busy after a finishing outcome");

   // An emitted command byte arms a fresh transfer
   a_start_arms: assert property (@(posedge clock) disable iff (reset)
      (fire && res_valid && res.kind == KIND_TX)
      |=> (busy_ff && byte_count_ff == 4'd0 && crc_ff == 8'd0))
      else $error("command byte sent without arming the receiver");

   // The byte count stays below the reply length during a transfer
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (byte_count_ff < expected_length_ff))
      else $error("byte count reached reply length while busy");

   // Status is flagged only on a clean status reply
   a_status_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status_valid)
      |-> (rsp_ff.outcome == OUT_OK && rsp_ff.reply_kind == RK_DUAL_STATUS))
      else $error("status flagged outside a clean status reply");

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for the dual encoder frame receiver: request stimulus, reply tracking.
`default_nettype none

module tb_top
   import defr_pkg::*;
();

   // Unused request command, ignored by the block
   localparam logic [1:0] CMD_SPARE = 2'd3;
   localparam int STORE_DEPTH  = 8;
   localparam int DRAIN_CYCLES = 4;
   localparam int MAX_REPORTS  = 10;

   typedef logic [7:0] reply_bytes_type [STORE_DEPTH];

   // Tracks the link master state and the response beats it owes
   class reply_tracker;
      rsp_payload_type due_beats[$];
      int              errors = 0;

      logic [15:0]     timeout_ticks    = TIMEOUT_RESET;
      logic            refuse_when_busy = 1'b0;

      bit              busy       = 1'b0;
      logic [1:0]      reply_kind = RK_DUAL;
      logic [3:0]      reply_len  = '0;
      logic [3:0]      byte_count = '0;
      logic [7:0]      crc        = '0;
      logic [15:0]     tick_count = '0;
      logic [7:0]      frame_bytes [STORE_DEPTH] = '{default: 8'h00};

      // One table step of the MSB-first CRC-8
      static function logic [7:0] crc_fold(logic [7:0] v);
         logic [7:0] c;
         c = v;
         repeat (8) c = {c[6:0], 1'b0} ^ (c[7] ? CRC_POLY : 8'h00);
         return c;
      endfunction

      function void set_config(logic [15:0] ticks, logic refuse);
         timeout_ticks    = ticks;
         refuse_when_busy = refuse;
      endfunction

      function int pending();
         return due_beats.size();
      endfunction

      function rsp_payload_type blank_outcome(logic [2:0] code);
         rsp_payload_type r;
         r         = '0;
         r.kind    = KIND_OUTCOME;
         r.outcome = code;
         return r;
      endfunction

      // Advance the master by one accepted request beat
      function void note_request(logic [1:0] cmd, logic [7:0] code, logic [7:0] rx);
         rsp_payload_type r;
         logic [1:0]      kind_next;
         logic [3:0]      len_next;
         r = '0;
         case (cmd)
            CMD_START: begin
               case (code)
                  CODE_DUAL: begin
                     kind_next = RK_DUAL;
                     len_next  = LEN_DUAL;
                  end
                  CODE_DUAL_STATUS: begin
                     kind_next = RK_DUAL_STATUS;
                     len_next  = LEN_DUAL_STATUS;
                  end
                  CODE_TEMP: begin
                     kind_next = RK_TEMP;
                     len_next  = LEN_TEMP;
                  end
                  default: begin
                     due_beats.push_back(blank_outcome(OUT_UNKNOWN));
                     return;
                  end
               endcase
               if (busy && refuse_when_busy) begin
                  due_beats.push_back(blank_outcome(OUT_BUSY));
                  return;
               end
               // fresh transfer, a running one is dropped silently
               busy       = 1'b1;
               reply_kind = kind_next;
               reply_len  = len_next;
               byte_count = '0;
               crc        = '0;
               tick_count = '0;
               r.kind     = KIND_TX;
               r.tx_byte  = code;
               due_beats.push_back(r);
            end
            CMD_BYTE: begin
               if (!busy) return;
               if (byte_count < STORE_DEPTH) frame_bytes[byte_count[2:0]] = rx;
               crc        = (byte_count == 0) ? rx : (rx ^ crc_fold(crc));
               byte_count = byte_count + 4'd1;
               if (byte_count < reply_len) return;
               busy = 1'b0;
               if (crc_fold(crc) != 8'h00) begin
                  r = blank_outcome(OUT_CRC);
               end else begin
                  r = blank_outcome(OUT_OK);
                  if (reply_kind == RK_TEMP) begin
                     r.temperature = {frame_bytes[1], frame_bytes[0]};
                  end else begin
                     r.inner_angle = {frame_bytes[2], frame_bytes[1], frame_bytes[0]};
                     r.outer_angle = {frame_bytes[5], frame_bytes[4], frame_bytes[3]};
                     if (reply_kind == RK_DUAL_STATUS) begin
                        r.encoder_status = frame_bytes[6];
                        r.status_valid   = 1'b1;
                     end
                  end
               end
               r.reply_kind = reply_kind;
               due_beats.push_back(r);
            end
            CMD_TICK: begin
               if (!busy || timeout_ticks == 0) return;
               if (tick_count >= timeout_ticks) begin
                  busy         = 1'b0;
                  r            = blank_outcome(OUT_TIMEOUT);
                  r.reply_kind = reply_kind;
                  due_beats.push_back(r);
               end else begin
                  tick_count = tick_count + 16'd1;
               end
            end
            default: ;
         endcase
      endfunction

      function void compare_field(string name, logic [23:0] want, logic [23:0] got);
         if (want !== got) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("mismatch on %s: expected %h, got %h", name, want, got);
         end
      endfunction

      // Match one response beat against the oldest owed beat
      function void check_response(rsp_payload_type got);
         rsp_payload_type want;
         if (due_beats.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("response beat with nothing owed: kind %b outcome %0d tx %h",
                        got.kind, got.outcome, got.tx_byte);
            return;
         end
         want = due_beats.pop_front();
         compare_field("kind", 24'(want.kind), 24'(got.kind));
         compare_field("tx_byte", 24'(want.tx_byte), 24'(got.tx_byte));
         compare_field("outcome", 24'(want.outcome), 24'(got.outcome));
         compare_field("inner_angle", want.inner_angle, got.inner_angle);
         compare_field("outer_angle", want.outer_angle, got.outer_angle);
         compare_field("encoder_status", 24'(want.encoder_status), 24'(got.encoder_status));
         compare_field("status_valid", 24'(want.status_valid), 24'(got.status_valid));
         compare_field("temperature", 24'(want.temperature), 24'(got.temperature));
         compare_field("reply_kind", 24'(want.reply_kind), 24'(got.reply_kind));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_we;
   logic        csr_index;
   logic [15:0] csr_wdata;

   defr_req_if req_if ();
   defr_rsp_if rsp_if ();

   reply_tracker book = new;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int beats_sent     = 0;

   dual_encoder_frame_receiver u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if)
   );

   always #10 clock = ~clock;

   // Watchdog
   initial begin
      #8000000;
      $display("FAIL dual_encoder_frame_receiver");
      $finish;
   end

   function automatic logic [7:0] pick_code();
      case ($urandom_range(0, 2))
         0:       return CODE_DUAL;
         1:       return CODE_DUAL_STATUS;
         default: return CODE_TEMP;
      endcase
   endfunction

   function automatic int reply_len_of(logic [7:0] code);
      case (code)
         CODE_DUAL:        return int'(LEN_DUAL);
         CODE_DUAL_STATUS: return int'(LEN_DUAL_STATUS);
         default:          return int'(LEN_TEMP);
      endcase
   endfunction

   // Last byte that brings the running CRC of a reply to zero
   function automatic logic [7:0] seal_byte(reply_bytes_type d, int len);
      logic [7:0] run;
      run = d[0];
      for (int i = 1; i < len - 1; i++) run = d[i] ^ reply_tracker::crc_fold(run);
      return reply_tracker::crc_fold(run);
   endfunction

   // One request beat, with a random gap in front
   task automatic send_beat(input logic [1:0] cmd, input logic [7:0] code,
                            input logic [7:0] rx);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.cmd          <= cmd;
      req_if.command_code <= code;
      req_if.rx_byte      <= rx;
      do @(posedge clock); while (!req_if.ready);
      book.note_request(cmd, code, rx);
      if (cmd <= CMD_TICK) beats_sent++;
   endtask

   // Reply bytes, optionally mixed with ticks and interrupting starts
   task automatic send_reply(input reply_bytes_type d, input int cut, input int tick_pct,
                             input int intr_pct);
      for (int i = 0; i < cut; i++) begin
         if ($urandom_range(0, 99) < tick_pct)
            send_beat(CMD_TICK, 8'($urandom), 8'($urandom));
         if ($urandom_range(0, 99) < intr_pct)
            send_beat(CMD_START, pick_code(), 8'($urandom));
         send_beat(CMD_BYTE, 8'($urandom), d[i]);
      end
   endtask

   // Start plus reply, mostly good CRC, sometimes corrupt or cut short
   task automatic send_transaction();
      reply_bytes_type d;
      logic [7:0]      code;
      int              len;
      int              cut;
      code = pick_code();
      len  = reply_len_of(code);
      for (int i = 0; i < STORE_DEPTH; i++) d[i] = 8'($urandom);
      d[len-1] = seal_byte(d, len);
      if ($urandom_range(0, 99) < 12) d[len-1] ^= 8'($urandom_range(1, 255));
      cut = ($urandom_range(0, 99) < 6) ? int'($urandom_range(0, len - 1)) : len;
      send_beat(CMD_START, code, 8'($urandom));
      send_reply(d, cut, 12, 4);
      // let a short timeout expire on a truncated reply
      if (cut < len && book.timeout_ticks != 0 && book.timeout_ticks <= 20)
         repeat (book.timeout_ticks + 1) send_beat(CMD_TICK, 8'($urandom), 8'($urandom));
   endtask

   task automatic run_random(input int count);
      int stop;
      stop = beats_sent + count;
      while (beats_sent < stop) begin
         if ($urandom_range(0, 99) < 75) send_transaction();
         else send_beat(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
      end
   endtask

   // Wait until every owed beat is back and the pipeline is quiet
   task automatic settle();
      req_if.valid <= 1'b0;
      while (book.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_config(input logic [15:0] ticks, input logic refuse);
      csr_we    <= 1'b1;
      csr_index <= CSR_TIMEOUT_TICKS;
      csr_wdata <= ticks;
      @(posedge clock);
      csr_index <= CSR_REFUSE_WHEN_BUSY;
      csr_wdata <= {15'd0, refuse};
      @(posedge clock);
      csr_we <= 1'b0;
      book.set_config(ticks, refuse);
   endtask

   // Response side: random stalls plus one long hold-off
   initial begin
      rsp_payload_type got;
      int              hold_left;
      int              seen;
      hold_left = 0;
      seen      = 0;
      forever begin
         if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            got.kind           = rsp_if.kind;
            got.tx_byte        = rsp_if.tx_byte;
            got.outcome        = rsp_if.outcome;
            got.inner_angle    = rsp_if.inner_angle;
            got.outer_angle    = rsp_if.outer_angle;
            got.encoder_status = rsp_if.encoder_status;
            got.status_valid   = rsp_if.status_valid;
            got.temperature    = rsp_if.temperature;
            got.reply_kind     = rsp_if.reply_kind;
            book.check_response(got);
            seen++;
            if (seen == 150) hold_left = 300;
         end
      end
   end

   // Request side: directed cases, then random phases per setting
   initial begin
      reply_bytes_type d;
      logic [15:0]     tmo_set [6] = '{16'd0, 16'd65535, 16'd2, 16'd10, 16'd1, 16'd7};
      logic            refuse_set [6] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};

      reset               <= 1'b1;
      csr_we              <= 1'b0;
      csr_index           <= CSR_TIMEOUT_TICKS;
      csr_wdata           <= '0;
      req_if.valid        <= 1'b0;
      req_if.cmd          <= CMD_START;
      req_if.command_code <= '0;
      req_if.rx_byte      <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct  = 38;
      recv_stall_pct = 68;
      write_config(TIMEOUT_RESET, 1'b0);

      // beats the idle block ignores, then refused codes
      send_beat(CMD_BYTE, 8'h00, 8'hFF);
      send_beat(CMD_TICK, 8'hFF, 8'h00);
      send_beat(CMD_SPARE, CODE_DUAL, 8'h55);
      send_beat(CMD_START, 8'h00, 8'h00);
      send_beat(CMD_START, 8'hFF, 8'hFF);

      // temperature reply, most negative reading
      d    = '{default: 8'h00};
      d[1] = 8'h80;
      d[2] = seal_byte(d, int'(LEN_TEMP));
      send_beat(CMD_START, CODE_TEMP, 8'h00);
      send_reply(d, int'(LEN_TEMP), 0, 0);

      // dual angle with status, full-scale inner and zero outer
      d    = '{8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'hA5, 8'h00};
      d[7] = seal_byte(d, int'(LEN_DUAL_STATUS));
      send_beat(CMD_START, CODE_DUAL_STATUS, 8'h00);
      send_reply(d, int'(LEN_DUAL_STATUS), 0, 0);

      // abort a running transfer, then a reply with a bad CRC
      send_beat(CMD_START, CODE_DUAL, 8'h00);
      send_beat(CMD_BYTE, 8'h00, 8'h12);
      send_beat(CMD_START, CODE_TEMP, 8'h00);
      d[0] = 8'hFF;
      d[1] = 8'h7F;
      d[2] = seal_byte(d, int'(LEN_TEMP)) ^ 8'h01;
      send_reply(d, int'(LEN_TEMP), 0, 0);
      settle();

      // refused start while busy, then timeout on the second tick
      write_config(16'd1, 1'b1);
      send_beat(CMD_START, CODE_DUAL, 8'h00);
      send_beat(CMD_START, CODE_DUAL_STATUS, 8'h00);
      send_beat(CMD_TICK, 8'h00, 8'h00);
      send_beat(CMD_TICK, 8'h00, 8'h00);
      settle();

      for (int s = 0; s < 6; s++) begin
         if (s < 2) begin
            send_idle_pct  = 38;
            recv_stall_pct = 68;
         end else if (s < 4) begin
            send_idle_pct  = 68;
            recv_stall_pct = 38;
         end else begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         write_config(tmo_set[s], refuse_set[s]);
         run_random(115);
         settle();
      end

      if (book.errors == 0 && book.pending() == 0) begin
         $display("PASS dual_encoder_frame_receiver");
      end else begin
         $display("FAIL dual_encoder_frame_receiver");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== dual_encoder_frame_receiver.f =====
rtl/defr_pkg.sv
rtl/defr_req_if.sv
rtl/defr_rsp_if.sv
rtl/defr_frame_store.sv
rtl/dual_encoder_frame_receiver.sv
bench/tb_top.sv
